// File: rtl/assert_macros.svh
// assertion macros used by the controller of the root search block
// no dependencies; every macro takes the clock and the active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define BRS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define BRS_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: rtl/brs_pkg.sv
// types, codes, saturation helpers and the estimate microprogram
// used by the controller, the datapath and the arithmetic units
package brs_pkg;

	localparam int FRAC_BITS_DEF = 40;
	localparam int VAL_W = 64;
	localparam int TOL_W = 41;
	localparam int CNT_W = 10;
	localparam int PC_W = 5;
	localparam int CFG_IDX_W = 8;

	localparam logic [TOL_W-1:0] TOL_RESET = 41'd110;
	localparam logic [CNT_W-1:0] MAXEV_RESET = 10'd100;
	localparam logic [CNT_W-1:0] CNT_MAX = 10'd1023;
	localparam logic [CNT_W-1:0] CNT_ENDS = 10'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TOL = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAXEV = 8'd1;

	localparam logic OP_START = 1'b0;
	localparam logic OP_REPLY = 1'b1;

	localparam logic signed [VAL_W-1:0] SMAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] SMIN = {1'b1, {(VAL_W-1){1'b0}}};

	localparam logic [PC_W-1:0] PC_IQI = 5'd0;
	localparam logic [PC_W-1:0] PC_SEC_POS = 5'd20;
	localparam logic [PC_W-1:0] PC_SEC_NEG = 5'd25;

	typedef enum logic [1:0] {
		KIND_EVAL, KIND_ROOT, KIND_NOBRACKET, KIND_LIMIT
	} kind_t;

	typedef enum logic [2:0] {
		OSEL_A, OSEL_B, OSEL_C, OSEL_PEND, OSEL_ZERO
	} out_sel_t;

	typedef enum logic [1:0] {ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV} alu_op_t;

	typedef enum logic [3:0] {
		SEL_A, SEL_B, SEL_C, SEL_FA, SEL_FB, SEL_FC, SEL_T0, SEL_T1, SEL_ACC
	} sel_t;

	typedef enum logic [1:0] {DST_T0, DST_T1, DST_ACC, DST_PEND} dst_t;

	typedef enum logic [2:0] {
		S_WAIT, S_CHECK2, S_CHECK3, S_ISSUE, S_BUSY, S_EMIT
	} state_t;

	typedef enum logic [1:0] {PH_IDLE, PH_FA, PH_FB, PH_INNER} phase_t;

	typedef struct packed {
		alu_op_t op;
		sel_t    x;
		sel_t    y;
		dst_t    dst;
		logic    last;
	} uop_t;

	typedef struct packed {
		kind_t    kind;
		out_sel_t sel;
	} emit_t;

	typedef struct packed {
		logic     load_start;
		logic     load_fa;
		logic     load_fb;
		logic     load_fc;
		logic     swap;
		logic     issue;
		uop_t     uop;
		logic     out_load;
		out_sel_t out_sel;
	} cmd_t;

	typedef struct packed {
		logic fa_small;
		logic fb_small;
		logic same_sign;
		logic fc_big;
		logic width_big;
		logic iqi_ok;
		logic fc_pos;
		logic op_done;
	} stat_t;

	// signed value from magnitude and sign, saturated
	function automatic logic signed [VAL_W-1:0] sat_mag(input logic [VAL_W-1:0] m,
		input logic neg);
		logic signed [VAL_W-1:0] r;
		if (neg) r = m[VAL_W-1] ? SMIN : -$signed(m);
		else r = m[VAL_W-1] ? SMAX : $signed(m);
		return r;
	endfunction

	function automatic logic signed [VAL_W-1:0] sat_addsub(
		input logic signed [VAL_W-1:0] a, input logic signed [VAL_W-1:0] b,
		input logic sub);
		logic signed [VAL_W:0] s;
		logic signed [VAL_W-1:0] r;
		if (sub) s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
		else s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
		if (s[VAL_W] != s[VAL_W-1]) r = s[VAL_W] ? SMIN : SMAX;
		else r = s[VAL_W-1:0];
		return r;
	endfunction

	function automatic uop_t mk(input alu_op_t op, input sel_t x, input sel_t y,
		input dst_t dst, input logic last);
		uop_t u;
		u.op = op;
		u.x = x;
		u.y = y;
		u.dst = dst;
		u.last = last;
		return u;
	endfunction

	// interpolation at 0..19, secant from c at 20..24, secant from b at 25..29
	function automatic uop_t ucode(input logic [PC_W-1:0] pc);
		uop_t u;
		case (pc)
			5'd0:  u = mk(ALU_SUB, SEL_FA, SEL_FB, DST_T0, 1'b0);
			5'd1:  u = mk(ALU_DIV, SEL_FB, SEL_T0, DST_T0, 1'b0);
			5'd2:  u = mk(ALU_MUL, SEL_A, SEL_T0, DST_T0, 1'b0);
			5'd3:  u = mk(ALU_SUB, SEL_FA, SEL_FC, DST_T1, 1'b0);
			5'd4:  u = mk(ALU_DIV, SEL_FC, SEL_T1, DST_T1, 1'b0);
			5'd5:  u = mk(ALU_MUL, SEL_T0, SEL_T1, DST_ACC, 1'b0);
			5'd6:  u = mk(ALU_SUB, SEL_FB, SEL_FA, DST_T0, 1'b0);
			5'd7:  u = mk(ALU_DIV, SEL_FA, SEL_T0, DST_T0, 1'b0);
			5'd8:  u = mk(ALU_MUL, SEL_B, SEL_T0, DST_T0, 1'b0);
			5'd9:  u = mk(ALU_SUB, SEL_FB, SEL_FC, DST_T1, 1'b0);
			5'd10: u = mk(ALU_DIV, SEL_FC, SEL_T1, DST_T1, 1'b0);
			5'd11: u = mk(ALU_MUL, SEL_T0, SEL_T1, DST_T0, 1'b0);
			5'd12: u = mk(ALU_ADD, SEL_ACC, SEL_T0, DST_ACC, 1'b0);
			5'd13: u = mk(ALU_SUB, SEL_FC, SEL_FA, DST_T0, 1'b0);
			5'd14: u = mk(ALU_DIV, SEL_FA, SEL_T0, DST_T0, 1'b0);
			5'd15: u = mk(ALU_MUL, SEL_C, SEL_T0, DST_T0, 1'b0);
			5'd16: u = mk(ALU_SUB, SEL_FC, SEL_FB, DST_T1, 1'b0);
			5'd17: u = mk(ALU_DIV, SEL_FB, SEL_T1, DST_T1, 1'b0);
			5'd18: u = mk(ALU_MUL, SEL_T0, SEL_T1, DST_T0, 1'b0);
			5'd19: u = mk(ALU_ADD, SEL_ACC, SEL_T0, DST_PEND, 1'b1);
			5'd20: u = mk(ALU_SUB, SEL_FC, SEL_FA, DST_T0, 1'b0);
			5'd21: u = mk(ALU_DIV, SEL_FC, SEL_T0, DST_T0, 1'b0);
			5'd22: u = mk(ALU_SUB, SEL_C, SEL_A, DST_T1, 1'b0);
			5'd23: u = mk(ALU_MUL, SEL_T1, SEL_T0, DST_T0, 1'b0);
			5'd24: u = mk(ALU_SUB, SEL_C, SEL_T0, DST_PEND, 1'b1);
			5'd25: u = mk(ALU_SUB, SEL_FB, SEL_FC, DST_T0, 1'b0);
			5'd26: u = mk(ALU_DIV, SEL_FB, SEL_T0, DST_T0, 1'b0);
			5'd27: u = mk(ALU_SUB, SEL_B, SEL_C, DST_T1, 1'b0);
			5'd28: u = mk(ALU_MUL, SEL_T1, SEL_T0, DST_T0, 1'b0);
			5'd29: u = mk(ALU_SUB, SEL_B, SEL_T0, DST_PEND, 1'b1);
			default: u = mk(ALU_ADD, SEL_ACC, SEL_T0, DST_PEND, 1'b1);
		endcase
		return u;
	endfunction

endpackage

// File: rtl/brs_mul.sv
// fixed-point multiplier: four 32x32 partial products, one per cycle
// depends on brs_pkg for widths and saturation
module brs_mul import brs_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [VAL_W-1:0] x,
	input  logic signed [VAL_W-1:0] y,
	output logic                    done,
	output logic signed [VAL_W-1:0] res
);

	localparam int HALF = VAL_W / 2;

	logic                    busy_q, done_q, neg_q;
	logic [2:0]              cnt_q;
	logic [VAL_W-1:0]        ma_q, mb_q, prod_q;
	logic [2*VAL_W-1:0]      acc_q, sh;
	logic signed [VAL_W-1:0] res_q;
	logic [1:0]              pi;
	logic [HALF-1:0]         ha, hb;
	logic [2*VAL_W-1:0]      addend;

	assign pi = cnt_q[1:0] - 2'd1;
	assign ha = cnt_q[1] ? ma_q[VAL_W-1:HALF] : ma_q[HALF-1:0];
	assign hb = cnt_q[0] ? mb_q[VAL_W-1:HALF] : mb_q[HALF-1:0];
	assign sh = acc_q >> FRAC_BITS;

	always_comb begin
		case (pi)
			2'd0: addend = {{VAL_W{1'b0}}, prod_q};
			2'd3: addend = {prod_q, {VAL_W{1'b0}}};
			default: addend = {{HALF{1'b0}}, prod_q, {HALF{1'b0}}};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 3'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= x[VAL_W-1] ^ y[VAL_W-1];
			ma_q <= x[VAL_W-1] ? -x : x;
			mb_q <= y[VAL_W-1] ? -y : y;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q <= 3'd3) prod_q <= ha * hb;
			if (cnt_q >= 3'd1 && cnt_q <= 3'd4) acc_q <= acc_q + addend;
			// high product bits beyond the format saturate
			if (cnt_q == 3'd5) begin
				if (|sh[2*VAL_W-1:VAL_W]) res_q <= neg_q ? SMIN : SMAX;
				else res_q <= sat_mag(sh[VAL_W-1:0], neg_q);
			end
		end
	end

	assign done = done_q;
	assign res = res_q;

endmodule

// File: rtl/brs_div.sv
// fixed-point divider, restoring, one quotient bit per cycle
// depends on brs_pkg for widths and saturation
module brs_div import brs_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [VAL_W-1:0] n,
	input  logic signed [VAL_W-1:0] d,
	output logic                    done,
	output logic signed [VAL_W-1:0] res
);

	logic                    busy_q, done_q, fin_q, neg_q;
	logic [6:0]              cnt_q;
	logic [VAL_W-1:0]        rem_q, lo_q, q_q, ud_q;
	logic signed [VAL_W-1:0] res_q;
	logic [VAL_W-1:0]        un, ud, hi;
	logic [VAL_W:0]          r2, r2s;
	logic                    quick;

	assign un = n[VAL_W-1] ? -n : n;
	assign ud = d[VAL_W-1] ? -d : d;
	assign hi = un >> (VAL_W - FRAC_BITS);
	// zero divisor or quotient out of range finish at once
	assign quick = (d == '0) || (hi >= ud);
	assign r2 = {rem_q, lo_q[VAL_W-1]};
	assign r2s = r2 - {1'b0, ud_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= 7'd0;
		end else begin
			done_q <= 1'b0;
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= !quick;
				done_q <= quick;
				cnt_q <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(VAL_W - 1)) begin
					busy_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= n[VAL_W-1] ^ d[VAL_W-1];
			ud_q <= ud;
			rem_q <= hi;
			lo_q <= un << FRAC_BITS;
			q_q <= '0;
			if (d == '0) res_q <= (n == '0) ? '0 : (n[VAL_W-1] ? SMIN : SMAX);
			else if (hi >= ud) res_q <= (n[VAL_W-1] ^ d[VAL_W-1]) ? SMIN : SMAX;
		end else if (busy_q) begin
			lo_q <= lo_q << 1;
			if (!r2s[VAL_W]) begin
				rem_q <= r2s[VAL_W-1:0];
				q_q <= {q_q[VAL_W-2:0], 1'b1};
			end else begin
				rem_q <= r2[VAL_W-1:0];
				q_q <= {q_q[VAL_W-2:0], 1'b0};
			end
		end else if (fin_q) begin
			res_q <= sat_mag(q_q, neg_q);
		end
	end

	assign done = done_q;
	assign res = res_q;

endmodule

// File: rtl/brs_dp.sv
// datapath: search points and values, operand select, add/sub, status
// depends on brs_pkg, brs_mul and brs_div
module brs_dp import brs_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	input  logic [TOL_W-1:0]        tol,
	input  logic signed [VAL_W-1:0] left_in,
	input  logic signed [VAL_W-1:0] right_in,
	input  logic signed [VAL_W-1:0] fv_in,
	output stat_t                   stat,
	output logic signed [VAL_W-1:0] point
);

	logic signed [VAL_W-1:0] a_q, b_q, c_q, fa_q, fb_q, fc_q;
	logic signed [VAL_W-1:0] t0_q, t1_q, acc_q, pend_q, x_q, y_q, point_q;
	logic                    go_q;
	alu_op_t                 op_q;
	dst_t                    dst_q;
	logic signed [VAL_W-1:0] selx, sely, wres, mul_res, div_res;
	logic                    mul_done, div_done, addsub, wen;
	logic [VAL_W:0]          tol_x;

	function automatic logic signed [VAL_W-1:0] pick(input sel_t s,
		input logic signed [VAL_W-1:0] a, input logic signed [VAL_W-1:0] b,
		input logic signed [VAL_W-1:0] c, input logic signed [VAL_W-1:0] fa,
		input logic signed [VAL_W-1:0] fb, input logic signed [VAL_W-1:0] fc,
		input logic signed [VAL_W-1:0] t0, input logic signed [VAL_W-1:0] t1,
		input logic signed [VAL_W-1:0] acc);
		logic signed [VAL_W-1:0] r;
		case (s)
			SEL_A:   r = a;
			SEL_B:   r = b;
			SEL_C:   r = c;
			SEL_FA:  r = fa;
			SEL_FB:  r = fb;
			SEL_FC:  r = fc;
			SEL_T0:  r = t0;
			SEL_T1:  r = t1;
			default: r = acc;
		endcase
		return r;
	endfunction

	// exact magnitude of a difference, one bit wider than the values
	function automatic logic [VAL_W:0] absdiff(input logic signed [VAL_W-1:0] p,
		input logic signed [VAL_W-1:0] q);
		logic signed [VAL_W:0] s;
		s = {p[VAL_W-1], p} - {q[VAL_W-1], q};
		return s[VAL_W] ? -s : s;
	endfunction

	assign selx = pick(cmd.uop.x, a_q, b_q, c_q, fa_q, fb_q, fc_q, t0_q, t1_q, acc_q);
	assign sely = pick(cmd.uop.y, a_q, b_q, c_q, fa_q, fb_q, fc_q, t0_q, t1_q, acc_q);

	brs_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(go_q && op_q == ALU_MUL),
		.x(x_q), .y(y_q), .done(mul_done), .res(mul_res)
	);

	brs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(go_q && op_q == ALU_DIV),
		.n(x_q), .d(y_q), .done(div_done), .res(div_res)
	);

	assign addsub = go_q && (op_q == ALU_ADD || op_q == ALU_SUB);
	assign wen = addsub || mul_done || div_done;

	always_comb begin
		if (addsub) wres = sat_addsub(x_q, y_q, op_q == ALU_SUB);
		else if (mul_done) wres = mul_res;
		else wres = div_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) go_q <= 1'b0;
		else go_q <= cmd.issue;
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			x_q <= selx;
			y_q <= sely;
			op_q <= cmd.uop.op;
			dst_q <= cmd.uop.dst;
		end
		if (wen) begin
			case (dst_q)
				DST_T0:  t0_q <= wres;
				DST_T1:  t1_q <= wres;
				DST_ACC: acc_q <= wres;
				default: pend_q <= wres;
			endcase
		end
		if (cmd.load_start) begin
			a_q <= left_in;
			b_q <= right_in;
		end
		if (cmd.load_fa) fa_q <= fv_in;
		if (cmd.load_fb) begin
			fb_q <= fv_in;
			// floor of the mean without overflow
			pend_q <= (a_q >>> 1) + (b_q >>> 1)
				+ $signed({{(VAL_W-1){1'b0}}, a_q[0] & b_q[0]});
		end
		if (cmd.load_fc) begin
			if (cmd.swap) begin
				if (fv_in[VAL_W-1]) begin
					a_q <= c_q;
					fa_q <= fc_q;
				end else begin
					b_q <= c_q;
					fb_q <= fc_q;
				end
			end
			c_q <= pend_q;
			fc_q <= fv_in;
		end
		if (cmd.out_load) begin
			case (cmd.out_sel)
				OSEL_A:    point_q <= a_q;
				OSEL_B:    point_q <= b_q;
				OSEL_C:    point_q <= c_q;
				OSEL_PEND: point_q <= pend_q;
				default:   point_q <= '0;
			endcase
		end
	end

	assign tol_x = {{(VAL_W+1-TOL_W){1'b0}}, tol};

	always_comb begin
		stat.fa_small = absdiff(fa_q, '0) < tol_x;
		stat.fb_small = absdiff(fb_q, '0) < tol_x;
		stat.same_sign = (fa_q != '0) && (fb_q != '0) && (fa_q[VAL_W-1] == fb_q[VAL_W-1]);
		stat.fc_big = absdiff(fc_q, '0) > tol_x;
		stat.width_big = absdiff(b_q, a_q) > tol_x;
		stat.iqi_ok = (absdiff(fa_q, fb_q) > tol_x) && (absdiff(fa_q, fc_q) > tol_x)
			&& (absdiff(fb_q, fc_q) > tol_x);
		stat.fc_pos = !fc_q[VAL_W-1] && (fc_q != '0);
		stat.op_done = wen;
	end

	assign point = point_q;

endmodule

// File: rtl/brs_ctrl.sv
// controller: search phase, evaluation count, microprogram sequencer, result valid
// depends on brs_pkg and assert_macros.svh
`include "assert_macros.svh"

module brs_ctrl import brs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic             s_op,
	output logic             m_tvalid,
	input  logic             m_tready,
	output kind_t            kind,
	output logic [CNT_W-1:0] evaluations,
	input  logic [CNT_W-1:0] max_evals,
	input  stat_t            stat,
	output cmd_t             cmd
);

	state_t           state_q, state_d;
	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] cnt_q, cnt_d, evals_q;
	logic [PC_W-1:0]  pc_q, pc_d;
	emit_t            emit_q, emit_d;
	kind_t            kind_q;
	logic             mvalid_q, s_acc;
	uop_t             cur;

	assign cur = ucode(pc_q);
	assign s_acc = s_tvalid && s_tready;

	// next state
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		cnt_d = cnt_q;
		pc_d = pc_q;
		emit_d = emit_q;
		case (state_q)
			S_WAIT: begin
				if (s_acc) begin
					if (s_op == OP_START) begin
						phase_d = PH_FA;
						cnt_d = '0;
						emit_d = '{kind: KIND_EVAL, sel: OSEL_A};
						state_d = S_EMIT;
					end else begin
						case (phase_q)
							PH_FA: begin
								phase_d = PH_FB;
								cnt_d = 10'd1;
								emit_d = '{kind: KIND_EVAL, sel: OSEL_B};
								state_d = S_EMIT;
							end
							PH_FB: begin
								cnt_d = CNT_ENDS;
								phase_d = PH_IDLE;
								state_d = S_CHECK2;
							end
							PH_INNER: begin
								if (cnt_q != CNT_MAX) cnt_d = cnt_q + 10'd1;
								state_d = S_CHECK3;
							end
							default: ; // reply with no search running is dropped
						endcase
					end
				end
			end
			S_CHECK2: begin
				state_d = S_EMIT;
				if (stat.fa_small) emit_d = '{kind: KIND_ROOT, sel: OSEL_A};
				else if (stat.fb_small) emit_d = '{kind: KIND_ROOT, sel: OSEL_B};
				else if (stat.same_sign) emit_d = '{kind: KIND_NOBRACKET, sel: OSEL_ZERO};
				else begin
					emit_d = '{kind: KIND_EVAL, sel: OSEL_PEND};
					phase_d = PH_INNER;
				end
			end
			S_CHECK3: begin
				if (!(stat.fc_big && stat.width_big)) begin
					emit_d = '{kind: KIND_ROOT, sel: OSEL_C};
					phase_d = PH_IDLE;
					state_d = S_EMIT;
				end else if (cnt_q >= max_evals) begin
					emit_d = '{kind: KIND_LIMIT, sel: OSEL_C};
					phase_d = PH_IDLE;
					state_d = S_EMIT;
				end else begin
					if (stat.iqi_ok) pc_d = PC_IQI;
					else if (stat.fc_pos) pc_d = PC_SEC_POS;
					else pc_d = PC_SEC_NEG;
					state_d = S_ISSUE;
				end
			end
			S_ISSUE: state_d = S_BUSY;
			S_BUSY: begin
				if (stat.op_done) begin
					if (cur.last) begin
						emit_d = '{kind: KIND_EVAL, sel: OSEL_PEND};
						state_d = S_EMIT;
					end else begin
						pc_d = pc_q + 5'd1;
						state_d = S_ISSUE;
					end
				end
			end
			S_EMIT: state_d = S_WAIT;
			default: state_d = S_WAIT;
		endcase
	end

	// outputs
	always_comb begin
		s_tready = (state_q == S_WAIT) && (!mvalid_q || m_tready);
		cmd.load_start = s_acc && (s_op == OP_START);
		cmd.load_fa = s_acc && (s_op == OP_REPLY) && (phase_q == PH_FA);
		cmd.load_fb = s_acc && (s_op == OP_REPLY) && (phase_q == PH_FB);
		cmd.load_fc = s_acc && (s_op == OP_REPLY) && (phase_q == PH_INNER);
		cmd.swap = cnt_q != CNT_ENDS;
		cmd.issue = state_q == S_ISSUE;
		cmd.uop = cur;
		cmd.out_load = state_q == S_EMIT;
		cmd.out_sel = emit_q.sel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_WAIT;
			phase_q <= PH_IDLE;
			cnt_q <= '0;
			pc_q <= '0;
			emit_q <= '{kind: KIND_EVAL, sel: OSEL_ZERO};
			mvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			cnt_q <= cnt_d;
			pc_q <= pc_d;
			emit_q <= emit_d;
			if (state_q == S_EMIT) mvalid_q <= 1'b1;
			else if (m_tready) mvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT) begin
			kind_q <= emit_q.kind;
			evals_q <= cnt_q;
		end
	end

	assign m_tvalid = mvalid_q;
	assign kind = kind_q;
	assign evaluations = evals_q;

	`BRS_ASSERT(a_acc_room, clk, arst_n, s_acc |-> (!mvalid_q || m_tready), "item taken with result slot full")
	`BRS_NEVER(a_emit_full, clk, arst_n, (state_q == S_EMIT) && mvalid_q, "result written over a waiting one")
	`BRS_ASSERT(a_busy_phase, clk, arst_n, (state_q == S_BUSY) |-> (phase_q == PH_INNER), "estimate running outside a search")
	`BRS_ASSERT(a_emit_next, clk, arst_n, (state_q == S_EMIT) |=> (mvalid_q && state_q == S_WAIT), "result not presented after emit")

endmodule

// File: rtl/bracketed_interpolation_root_search.sv
// top level of the bracketed interpolation root search sequencer
// depends on brs_pkg, brs_ctrl and brs_dp; holds the configuration registers
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  tuser: operation; tdata: left, right, f value
//   m_*      out  m_tvalid/m_tready  tuser: kind; tdata: point, evaluations
//   cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// a start item or a reply for an interval end goes from accept through the emit state
// to the result register, the reply for the second end through the end check first;
// an interior reply runs the estimate program (interpolation or secant) on one shared
// divider and a multiplier; one item is in work at a time and a new one is taken only
// when the result register is free or is taken in the same cycle
// asynchronous reset clears control state; no clearing pass
module bracketed_interpolation_root_search import brs_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [191:0]         s_tdata,  // left_end, right_end, function_value
	input  logic [0:0]           s_tuser,  // operation
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [79:0]          m_tdata,  // point, evaluations, zero fill
	output logic [1:0]           m_tuser,  // kind
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TOL_W-1:0]     cfg_data
);

	logic [TOL_W-1:0]        tol_q;
	logic [CNT_W-1:0]        maxev_q, evals;
	kind_t                   kind;
	stat_t                   stat;
	cmd_t                    cmd;
	logic signed [VAL_W-1:0] point;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
			maxev_q <= MAXEV_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_TOL) tol_q <= cfg_data;
			else if (cfg_index == REG_MAXEV) maxev_q <= cfg_data[CNT_W-1:0];
		end
	end

	brs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_op(s_tuser[0]),
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.kind(kind), .evaluations(evals), .max_evals(maxev_q),
		.stat(stat), .cmd(cmd)
	);

	brs_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .tol(tol_q),
		.left_in(s_tdata[63:0]), .right_in(s_tdata[127:64]), .fv_in(s_tdata[191:128]),
		.stat(stat), .point(point)
	);

	assign m_tdata = {6'b0, evals, point};
	assign m_tuser = kind;

endmodule
